// ----- sv/bbp_pkg.sv -----
// package for the bimodal branch predictor
// holds field widths, the mode codes and the counter prediction and update functions
// no dependencies
package bbp_pkg;

  // field widths
  localparam int unsigned AddrW       = 64;
  localparam int unsigned InTdataW    = 72;
  localparam int unsigned OutTdataW   = 8;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned CntW        = 3;
  localparam int unsigned BitCntW     = $clog2(AddrW);
  localparam int unsigned DefEntries  = 1024;

  // predictor scheme codes
  typedef enum logic [ModeW-1:0] {
    MODE_STATIC = 2'd0,
    MODE_ONEBIT = 2'd1,
    MODE_TWOBIT = 2'd2,
    MODE_THREEBIT = 2'd3
  } mode_e;

  localparam mode_e ModeReset = MODE_TWOBIT;

  // counter saturation and prediction thresholds
  localparam logic [CntW-1:0] TwoBitTop   = 3'd3;
  localparam logic [CntW-1:0] ThreeBitTop = 3'd7;
  localparam logic [CntW-1:0] TwoBitThr   = 3'd2;
  localparam logic [CntW-1:0] ThreeBitThr = 3'd4;

  // prediction from the stored entry, before the update
  function automatic logic predict(mode_e mode, logic [CntW-1:0] cur);
    logic p;
    unique case (mode)
      MODE_STATIC:   p = 1'b0;
      MODE_ONEBIT:   p = (cur == 3'd1);
      MODE_TWOBIT:   p = (cur >= TwoBitThr);
      MODE_THREEBIT: p = (cur >= ThreeBitThr);
    endcase
    return p;
  endfunction

  // entry value after the outcome is folded in
  function automatic logic [CntW-1:0] cnt_next(mode_e mode, logic [CntW-1:0] cur,
                                               logic taken);
    logic [CntW-1:0] top;
    logic [CntW-1:0] nxt;
    top = (mode == MODE_THREEBIT) ? ThreeBitTop : TwoBitTop;
    unique case (mode)
      MODE_STATIC: nxt = cur;
      MODE_ONEBIT: nxt = {{(CntW-1){1'b0}}, taken};
      MODE_TWOBIT, MODE_THREEBIT: begin
        if (taken) begin
          nxt = (cur >= top) ? top : cur + 3'd1;
        end else begin
          nxt = (cur == 3'd0) ? 3'd0 : cur - 3'd1;
        end
      end
    endcase
    return nxt;
  endfunction

endpackage

// ----- sv/bimodal_branch_predictor.sv -----
// sequence: with a power-of-two table the input transfer is followed by S_READ and S_UPD,
// and S_UPD waits until the output register is free; other sizes first reduce the address
// by the table size, one 16-bit digit per S_MUL and S_MOD pair, before S_READ
// the next branch is taken only after the single read-modify-write of the counter memory per branch
// reset: asynchronous, active low; mode returns to two-bit and a clearing pass zeroes
// the counter table, one entry at a time, before the first input is taken
//
// top level of the bimodal branch predictor
// depends on bbp_pkg
module bimodal_branch_predictor
  import bbp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DefEntries
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write: predictor_mode
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ModeW-1:0]     cfg_data_i,
  // resolved branches
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,   // [63:0] branch_address, [64] taken_outcome
  // predictions
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o    // [0] predicted_taken
);

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam bit          IsPow2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam logic [AddrW-1:0] IdxMask = AddrW'(TABLE_ENTRIES - 1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(TABLE_ENTRIES - 1);

  // address reduction for other sizes: 16-bit digits, remainder through a reciprocal
  localparam int unsigned          ChunkW    = 16;
  localparam int unsigned          NumChunks = AddrW / ChunkW;
  localparam int unsigned          ChunkCntW = $clog2(NumChunks);
  localparam logic [ChunkCntW-1:0] LastChunk = ChunkCntW'(NumChunks - 1);
  localparam logic [2*ChunkW-1:0]  EntriesW  = (2*ChunkW)'(TABLE_ENTRIES);
  localparam logic [2*ChunkW-1:0]  Recip     =
    (2*ChunkW)'((64'd1 << (2*ChunkW)) / TABLE_ENTRIES);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_MOD   = 6'b001000,
    S_READ  = 6'b010000,
    S_UPD   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  mode_e                mode_q;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic                 taken_q, taken_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [ChunkCntW-1:0] chunk_q, chunk_d;
  logic [ChunkW-1:0]    quo_q, quo_d;
  logic                 out_valid_q, out_valid_d;
  logic                 pred_q, pred_d;

  logic [CntW-1:0]      mem [TABLE_ENTRIES];
  logic [CntW-1:0]      rd_data_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [CntW-1:0]      mem_wdata;

  logic                 in_xfer;
  logic                 out_free;
  logic [2*ChunkW-1:0]  mod_x;
  logic [4*ChunkW-1:0]  mod_mul;
  logic [2*ChunkW-1:0]  mod_diff;
  logic [2*ChunkW-1:0]  mod_rem;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW-1){1'b0}}, pred_q};

  // running remainder with the next address digit appended, below TABLE_ENTRIES * 2^16
  assign mod_x    = {ChunkW'(idx_q), addr_q[AddrW-1 -: ChunkW]};
  // quotient estimate from the reciprocal, at most one below the true quotient
  assign mod_mul  = (4*ChunkW)'(mod_x) * (4*ChunkW)'(Recip);
  // remainder from the registered estimate, one corrective subtract
  assign mod_diff = mod_x - (2*ChunkW)'(quo_q) * EntriesW;
  assign mod_rem  = (mod_diff >= EntriesW) ? mod_diff - EntriesW : mod_diff;

  // sequencer: clear, take a branch, reduce, read, update
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    taken_d     = taken_q;
    idx_d       = idx_q;
    chunk_d     = chunk_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    pred_d      = pred_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = cnt_next(mode_q, rd_data_q, taken_q);
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        idx_d     = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          addr_d  = s_axis_tdata_i[AddrW-1:0];
          taken_d = s_axis_tdata_i[AddrW];
          if (IsPow2) begin
            idx_d   = IdxW'(s_axis_tdata_i[AddrW-1:0] & IdxMask);
            state_d = S_READ;
          end else begin
            idx_d   = '0;
            chunk_d = '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        quo_d   = mod_mul[3*ChunkW-1:2*ChunkW];
        state_d = S_MOD;
      end
      S_MOD: begin
        idx_d   = mod_rem[IdxW-1:0];
        addr_d  = {addr_q[AddrW-ChunkW-1:0], {ChunkW{1'b0}}};
        chunk_d = chunk_q + 1'b1;
        if (chunk_q == LastChunk) begin
          state_d = S_READ;
        end else begin
          state_d = S_MUL;
        end
      end
      S_READ: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          mem_we      = (mode_q != MODE_STATIC);
          pred_d      = predict(mode_q, rd_data_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= ModeReset;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= mode_e'(cfg_data_i);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    taken_q <= taken_d;
    chunk_q <= chunk_d;
    quo_q   <= quo_d;
    pred_q  <= pred_d;
  end

  // counter table, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == S_READ) begin
      rd_data_q <= mem[idx_q];
    end
  end

`ifndef SYNTH
  // the table index never leaves the table while a lookup is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_UPD) |-> (32'(idx_q) < 32'(TABLE_ENTRIES)))
    else $error("table index out of range");

  // static mode never writes the table outside the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != S_CLEAR) |-> (mode_q != MODE_STATIC))
    else $error("table written in static mode");

  // no branch is taken in before the clearing pass is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_xfer)
    else $error("input transfer during clearing pass");

  // a finished update always puts a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("update finished without a result");

  // a read is always followed by the update of the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_UPD && $stable(idx_q)))
    else $error("read not followed by its update");
`endif

endmodule
